// ===== rtl/hbse_pkg.sv =====
// Shared types, constants and choice helpers for the halo box segment enumerator.
// No dependencies; imported by hbse_lane, hbse_merge and the top level.
package hbse_pkg;

  localparam int COORD_W  = 16;
  localparam int AXES     = 3;
  localparam int NUM_W    = 5;
  localparam int DIM_W    = 2;

  localparam int S_FIELDS_W = DIM_W + 3 * AXES * COORD_W;
  localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
  localparam int M_FIELDS_W = 2 * AXES * COORD_W + NUM_W;
  localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

  // per-axis interval choice
  localparam logic [1:0] CH_LEFT   = 2'd0;
  localparam logic [1:0] CH_CENTRE = 2'd1;
  localparam logic [1:0] CH_RIGHT  = 2'd2;

  typedef logic [COORD_W-1:0] coord_t;

  // one axis: offset and length of left/centre/right, non-empty mask, bad flag
  typedef struct packed {
    logic [2:0][COORD_W-1:0] off;
    logic [2:0][COORD_W-1:0] len;
    logic [2:0]              nz;
    logic                    bad;
  } lane_t;

  typedef struct packed {
    logic [AXES-1:0][COORD_W-1:0] off;
    logic [AXES-1:0][COORD_W-1:0] len;
    logic [NUM_W-1:0]             num;
    logic                         last;
    logic                         status;
  } seg_t;

  function automatic logic [1:0] lo_choice(input logic [2:0] m);
    logic [1:0] d;
    if (m[0]) d = CH_LEFT;
    else if (m[1]) d = CH_CENTRE;
    else d = CH_RIGHT;
    return d;
  endfunction

  function automatic logic [1:0] hi_choice(input logic [2:0] m);
    logic [1:0] d;
    if (m[2]) d = CH_RIGHT;
    else if (m[1]) d = CH_CENTRE;
    else d = CH_LEFT;
    return d;
  endfunction

  // next non-empty choice above d: {found, digit}
  function automatic logic [2:0] next_choice(input logic [2:0] m, input logic [1:0] d);
    logic [2:0] r;
    r = {1'b0, CH_LEFT};
    case (d)
      CH_LEFT: begin
        if (m[1]) r = {1'b1, CH_CENTRE};
        else if (m[2]) r = {1'b1, CH_RIGHT};
      end
      CH_CENTRE: begin
        if (m[2]) r = {1'b1, CH_RIGHT};
      end
      default: r = {1'b0, CH_LEFT};
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/hbse_lane.sv =====
// One axis lane: splits the mesh extent into left, centre and right intervals.
// Depends on hbse_pkg.
module hbse_lane (
  input  logic                 clk,
  input  logic                 load,
  input  logic                 used,
  input  hbse_pkg::coord_t     mesh,
  input  hbse_pkg::coord_t     inner,
  input  hbse_pkg::coord_t     start,
  output hbse_pkg::lane_t      lane
);
  import hbse_pkg::*;

  logic [COORD_W:0] sum;
  coord_t           right_len;
  lane_t            lane_next;

  assign sum       = {1'b0, start} + {1'b0, inner};
  assign right_len = mesh - sum[COORD_W-1:0];

  always_comb begin
    lane_next = '0;
    if (used) begin
      lane_next.off[0] = '0;
      lane_next.len[0] = start;
      lane_next.off[1] = start;
      lane_next.len[1] = inner;
      lane_next.off[2] = sum[COORD_W-1:0];
      lane_next.len[2] = right_len;
      lane_next.nz     = {right_len != '0, 1'b1, start != '0};
      lane_next.bad    = (inner == '0) || (sum > {1'b0, mesh});
    end else begin
      lane_next.nz = 3'b001;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      lane <= lane_next;
    end
  end

endmodule

// ===== rtl/hbse_merge.sv =====
// Merging sequencer: steps the per-axis choice odometer over non-empty
// intervals and registers one segment beat per cycle while m_ready allows. Depends on hbse_pkg.
module hbse_merge (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  hbse_pkg::lane_t [hbse_pkg::AXES-1:0] lanes,
  output logic                           ready,
  output logic                           m_valid,
  input  logic                           m_ready,
  output hbse_pkg::seg_t                 m_seg
);
  import hbse_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_LOAD, ST_RUN} state_t;

  state_t                   state;
  logic [AXES-1:0][1:0]     dig;
  logic [AXES-1:0][1:0]     dig_next;
  logic [NUM_W-1:0]         count;
  logic                     bad;
  logic                     last;
  seg_t                     seg_next;

  always_comb begin
    logic       carry;
    logic [2:0] nc;
    bad   = 1'b0;
    last  = 1'b1;
    carry = 1'b1;
    for (int a = 0; a < AXES; a++) begin
      bad  = bad | lanes[a].bad;
      last = last & (dig[a] == hi_choice(lanes[a].nz));
    end
    for (int a = AXES - 1; a >= 0; a--) begin
      nc = next_choice(lanes[a].nz, dig[a]);
      dig_next[a] = dig[a];
      if (carry) begin
        if (nc[2]) begin
          dig_next[a] = nc[1:0];
          carry = 1'b0;
        end else begin
          dig_next[a] = lo_choice(lanes[a].nz);
        end
      end
    end
  end

  always_comb begin
    seg_next = '0;
    if (bad) begin
      seg_next.last   = 1'b1;
      seg_next.status = 1'b1;
    end else begin
      for (int a = 0; a < AXES; a++) begin
        case (dig[a])
          CH_LEFT:   begin seg_next.off[a] = lanes[a].off[0]; seg_next.len[a] = lanes[a].len[0]; end
          CH_CENTRE: begin seg_next.off[a] = lanes[a].off[1]; seg_next.len[a] = lanes[a].len[1]; end
          CH_RIGHT:  begin seg_next.off[a] = lanes[a].off[2]; seg_next.len[a] = lanes[a].len[2]; end
          default:   begin seg_next.off[a] = '0; seg_next.len[a] = '0; end
        endcase
      end
      seg_next.num  = count;
      seg_next.last = last;
    end
  end

  assign ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      m_valid <= 1'b0;
      dig     <= '0;
      count   <= '0;
    end else begin
      if (m_valid && m_ready && (state != ST_RUN)) begin
        m_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (start) state <= ST_LOAD;
        end
        ST_LOAD: begin
          for (int a = 0; a < AXES; a++) dig[a] <= lo_choice(lanes[a].nz);
          count <= '0;
          state <= ST_RUN;
        end
        ST_RUN: begin
          if (!m_valid || m_ready) begin
            m_valid <= 1'b1;
            m_seg   <= seg_next;
            if (bad || last) begin
              state <= ST_IDLE;
            end else begin
              dig   <= dig_next;
              count <= count + 1'b1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/halo_box_segment_enumerator.sv =====
// Halo box segment enumerator. One input beat describes a box; each result
// beat is one segment of the 3x3x3 split (empty only when no axis is used), or a single error beat.
// A box yields 1 to 27 segments. The three axis lanes are registered as
// the box is taken, ST_LOAD then sets the starting choices, and the choice
// odometer emits one segment a cycle while m_tready is high into the single
// output register. s_tready is high while no item is in work, so the next
// box is taken while the last segment still waits.
// Depends on hbse_pkg, hbse_lane and hbse_merge.
module halo_box_segment_enumerator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // dim_count, mesh_x, mesh_y, mesh_z, inner_x, inner_y, inner_z,
  // start_x, start_y, start_z (lowest bits first), zero padded
  input  logic [hbse_pkg::S_TDATA_W-1:0] s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // seg_off_x, seg_off_y, seg_off_z, seg_len_x, seg_len_y, seg_len_z,
  // seg_number (lowest bits first), zero padded
  output logic [hbse_pkg::M_TDATA_W-1:0] m_tdata,
  output logic                          m_tlast,   // seg_last
  output logic                          m_tuser    // box_status
);
  import hbse_pkg::*;

  localparam int MESH_LO  = DIM_W;
  localparam int INNER_LO = DIM_W + AXES * COORD_W;
  localparam int START_LO = DIM_W + 2 * AXES * COORD_W;

  logic                     accept;
  logic [DIM_W-1:0]         dim_count;
  lane_t [AXES-1:0]         lanes;
  seg_t                     seg;

  assign accept    = s_tvalid && s_tready;
  assign dim_count = s_tdata[DIM_W-1:0];

  for (genvar a = 0; a < AXES; a++) begin : g_lane
    hbse_lane u_lane (
      .clk   (clk),
      .load  (accept),
      .used  (dim_count > DIM_W'(a)),
      .mesh  (s_tdata[MESH_LO  + a*COORD_W +: COORD_W]),
      .inner (s_tdata[INNER_LO + a*COORD_W +: COORD_W]),
      .start (s_tdata[START_LO + a*COORD_W +: COORD_W]),
      .lane  (lanes[a])
    );
  end

  hbse_merge u_merge (
    .clk     (clk),
    .rst     (rst),
    .start   (accept),
    .lanes   (lanes),
    .ready   (s_tready),
    .m_valid (m_tvalid),
    .m_ready (m_tready),
    .m_seg   (seg)
  );

  assign m_tdata = {{(M_TDATA_W - M_FIELDS_W){1'b0}}, seg.num, seg.len, seg.off};
  assign m_tlast = seg.last;
  assign m_tuser = seg.status;

  a_err_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast)
    else $error("error beat without last");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("error beat carries segment data");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("input taken while item in work");

  a_num: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> seg.num <= NUM_W'(26))
    else $error("segment number beyond range");

endmodule

// ===== dv/halo_box_segment_enumerator_test.sv =====
`timescale 1ns / 1ps
// Testbench for halo_box_segment_enumerator: directed boxes, then random ones,
// with every result beat checked against predicted or listed segments. Needs hbse_pkg.
module halo_box_segment_enumerator_test;
  import hbse_pkg::*;

  localparam logic ST_OK  = 1'b0;
  localparam logic ST_BAD = 1'b1;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_BOXES = 300;
  localparam int DRAIN_AT = 100;

  typedef struct packed {
    logic [2:0][COORD_W-1:0] start;
    logic [2:0][COORD_W-1:0] inner;
    logic [2:0][COORD_W-1:0] mesh;
    logic [DIM_W-1:0]        dim;
  } box_t;

  typedef struct packed {
    logic [2:0][COORD_W-1:0] off;
    logic [2:0][COORD_W-1:0] len;
    logic [NUM_W-1:0]        num;
    logic                    last;
    logic                    status;
  } seg_rec_t;

  typedef struct {
    box_t     b;
    bit       typed;
    seg_rec_t want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic m_tlast;
  logic m_tuser;

  seg_rec_t expected_segs[$];
  int errors = 0;
  int cycle_count = 0;
  bit calm = 1'b0;

  halo_box_segment_enumerator dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast),
    .m_tuser(m_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("halo_box_segment_enumerator_test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    m_tready <= calm || ($urandom_range(99) >= 29);
  end

  function automatic box_t mk_box(int dim, int mx, int ix, int sx, int my, int iy, int sy,
                                  int mz, int iz, int sz);
    box_t b;
    b.dim = DIM_W'(dim);
    b.mesh  = {COORD_W'(mz), COORD_W'(my), COORD_W'(mx)};
    b.inner = {COORD_W'(iz), COORD_W'(iy), COORD_W'(ix)};
    b.start = {COORD_W'(sz), COORD_W'(sy), COORD_W'(sx)};
    return b;
  endfunction

  function automatic seg_rec_t lone_seg(logic status, int len_x);
    seg_rec_t r;
    r = '0;
    r.len[0] = COORD_W'(len_x);
    r.last = 1'b1;
    r.status = status;
    return r;
  endfunction

  // expected segments of one box, in choice order, appended to expected_segs
  task automatic predict_segments(input box_t b);
    seg_rec_t segs[$];
    seg_rec_t r;
    logic [1:0] dig [3];
    logic [COORD_W:0] edge_hi;
    bit keep;
    int axes;
    axes = b.dim;
    for (int a = 0; a < axes; a++) begin
      edge_hi = {1'b0, b.start[a]} + {1'b0, b.inner[a]};
      if (b.inner[a] == '0 || edge_hi > {1'b0, b.mesh[a]}) begin
        expected_segs.push_back(lone_seg(ST_BAD, 0));
        return;
      end
    end
    for (int c = 0; c < 27; c++) begin
      dig[0] = 2'(c / 9);
      dig[1] = 2'((c / 3) % 3);
      dig[2] = 2'(c % 3);
      r = '0;
      keep = 1'b1;
      for (int a = 0; a < 3; a++) begin
        if (a >= axes) begin
          if (dig[a] != CH_LEFT) keep = 1'b0;
        end else begin
          case (dig[a])
            CH_LEFT: begin
              r.off[a] = '0;
              r.len[a] = b.start[a];
            end
            CH_CENTRE: begin
              r.off[a] = b.start[a];
              r.len[a] = b.inner[a];
            end
            default: begin
              r.off[a] = b.start[a] + b.inner[a];
              r.len[a] = b.mesh[a] - r.off[a];
            end
          endcase
          if (r.len[a] == '0) keep = 1'b0;
        end
      end
      if (keep) begin
        r.num = NUM_W'(segs.size());
        r.status = ST_OK;
        segs.push_back(r);
      end
    end
    segs[segs.size() - 1].last = 1'b1;
    foreach (segs[i]) expected_segs.push_back(segs[i]);
  endtask

  function automatic logic [COORD_W-1:0] junk_coord();
    logic [COORD_W-1:0] v;
    case ($urandom_range(3))
      0: v = COORD_W'($urandom_range(7));
      1: v = COORD_W'($urandom_range(255));
      2: v = COORD_W'($urandom_range(65535));
      default: v = $urandom_range(1) ? '1 : '0;
    endcase
    return v;
  endfunction

  // mostly well-formed boxes; some raw noise and some with one axis broken
  function automatic box_t rand_box();
    box_t b;
    int mode, m, s, n, a;
    mode = $urandom_range(99);
    b.dim = (mode < 5) ? '0 : DIM_W'($urandom_range(1, 3));
    for (int i = 0; i < 3; i++) begin
      b.mesh[i] = junk_coord();
      b.inner[i] = junk_coord();
      b.start[i] = junk_coord();
    end
    if (mode < 12) return b;
    for (int i = 0; i < int'(b.dim); i++) begin
      case ($urandom_range(2))
        0: m = $urandom_range(1, 8);
        1: m = $urandom_range(1, 65535);
        default: m = 65535;
      endcase
      case ($urandom_range(3))
        0: s = 0;
        1: s = m - 1;
        default: s = $urandom_range(0, m - 1);
      endcase
      case ($urandom_range(3))
        0: n = m - s;
        1: n = 1;
        default: n = $urandom_range(1, m - s);
      endcase
      b.mesh[i] = COORD_W'(m);
      b.start[i] = COORD_W'(s);
      b.inner[i] = COORD_W'(n);
    end
    if (mode >= 88 && b.dim != '0) begin
      a = $urandom_range(0, int'(b.dim) - 1);
      case ($urandom_range(2))
        0: b.inner[a] = '0;
        1: b.inner[a] = b.mesh[a] - b.start[a] + 1'b1;
        default: begin
          b.start[a] = '1;
          b.inner[a] = COORD_W'($urandom_range(1, 65535));
        end
      endcase
    end
    return b;
  endfunction

  task automatic send_box(input box_t b, input bit typed, input seg_rec_t want);
    if (!calm && $urandom_range(99) < 29) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= S_TDATA_W'(b);
    do @(posedge clk); while (!s_tready);
    if (typed) expected_segs.push_back(want);
    else predict_segments(b);
  endtask

  task automatic check_field(input string name, input logic [COORD_W-1:0] exp_v,
                             input logic [COORD_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin : seg_monitor
    seg_rec_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.off = m_tdata[3*COORD_W-1:0];
      got.len = m_tdata[6*COORD_W-1:3*COORD_W];
      got.num = m_tdata[6*COORD_W +: NUM_W];
      got.last = m_tlast;
      got.status = m_tuser;
      if (expected_segs.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual %h", $time, got);
        errors++;
      end else begin
        want = expected_segs.pop_front();
        check_field("seg_off_x", want.off[0], got.off[0]);
        check_field("seg_off_y", want.off[1], got.off[1]);
        check_field("seg_off_z", want.off[2], got.off[2]);
        check_field("seg_len_x", want.len[0], got.len[0]);
        check_field("seg_len_y", want.len[1], got.len[1]);
        check_field("seg_len_z", want.len[2], got.len[2]);
        check_field("seg_number", COORD_W'(want.num), COORD_W'(got.num));
        check_field("seg_last", COORD_W'(want.last), COORD_W'(got.last));
        check_field("box_status", COORD_W'(want.status), COORD_W'(got.status));
      end
    end
  end

  initial begin : stimulus
    plan_row_t plan[$];
    // one, two and three axes with every interval present
    plan.push_back('{mk_box(1, 10, 4, 3, 0, 0, 0, 0, 0, 0), 1'b0, '0});
    plan.push_back('{mk_box(2, 10, 4, 3, 8, 2, 2, 0, 0, 0), 1'b0, '0});
    plan.push_back('{mk_box(3, 10, 4, 3, 8, 2, 2, 6, 2, 1), 1'b0, '0});
    // empty left on x, empty right on y
    plan.push_back('{mk_box(3, 9, 5, 0, 7, 3, 4, 5, 1, 2), 1'b0, '0});
    // inner box fills the whole axis, or all but one unit at each end
    plan.push_back('{mk_box(1, 65535, 65535, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                     lone_seg(ST_OK, 65535)});
    plan.push_back('{mk_box(3, 65535, 65533, 1, 65535, 65533, 1, 65535, 65533, 1),
                     1'b0, '0});
    // invalid boxes
    plan.push_back('{mk_box(1, 100, 0, 5, 0, 0, 0, 0, 0, 0), 1'b1, lone_seg(ST_BAD, 0)});
    plan.push_back('{mk_box(3, 10, 2, 2, 10, 2, 2, 10, 8, 3), 1'b1, lone_seg(ST_BAD, 0)});
    plan.push_back('{mk_box(1, 65535, 65535, 65535, 0, 0, 0, 0, 0, 0), 1'b1,
                     lone_seg(ST_BAD, 0)});
    plan.push_back('{mk_box(3, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, lone_seg(ST_BAD, 0)});
    plan.push_back('{mk_box(2, 20, 5, 5, 4, 5, 0, 0, 0, 0), 1'b1, lone_seg(ST_BAD, 0)});
    // broken axis beyond dim_count is ignored
    plan.push_back('{mk_box(2, 12, 3, 4, 6, 2, 1, 3, 0, 65535), 1'b0, '0});
    plan.push_back('{mk_box(1, 1, 1, 0, 65535, 65535, 65535, 65535, 65535, 65535),
                     1'b0, '0});
    // no axes: a single empty segment
    plan.push_back('{mk_box(0, 65535, 0, 65535, 0, 65535, 0, 65535, 0, 65535), 1'b1,
                     lone_seg(ST_OK, 0)});
    plan.push_back('{mk_box(3, 2, 1, 1, 3, 1, 1, 3, 1, 0), 1'b0, '0});

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    foreach (plan[i]) send_box(plan[i].b, plan[i].typed, plan[i].want);

    for (int k = 0; k < RANDOM_BOXES; k++) begin
      if (k == DRAIN_AT) begin
        s_tvalid <= 1'b0;
        do @(posedge clk); while (expected_segs.size() != 0);
      end
      calm = (k >= 150 && k < 230);
      send_box(rand_box(), 1'b0, '0);
    end
    s_tvalid <= 1'b0;
    calm = 1'b0;

    while (expected_segs.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("halo_box_segment_enumerator_test passed");
    end else begin
      $display("halo_box_segment_enumerator_test failed");
    end
    $finish;
  end

endmodule

// ===== halo_box_segment_enumerator.f =====
rtl/hbse_pkg.sv
rtl/hbse_lane.sv
rtl/hbse_merge.sv
rtl/halo_box_segment_enumerator.sv
dv/halo_box_segment_enumerator_test.sv
